// ===== rtl/quad_trapezoid_fracture_assert.svh =====
// assertion macros for the quadrilateral fracture block
// used by the port checker; expects clk and rst_n in the calling scope
`ifndef QUAD_TRAPEZOID_FRACTURE_ASSERT_SVH
`define QUAD_TRAPEZOID_FRACTURE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define QTF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define QTF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qtf_pkg.sv =====
// shared constants and types for the quadrilateral trapezoid fracture block
// no dependencies
`default_nettype none

package qtf_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TAG_WIDTH       = 16;
    localparam int TOL_WIDTH       = 16;
    localparam int NUM_PIECES      = 3;

    localparam logic [TOL_WIDTH-1:0] HEIGHT_TOL_RESET = 16'd5;

    // piece codes, also used as bit positions of the piece mask
    typedef enum logic [1:0] {
        KIND_LOWER  = 2'd0,
        KIND_UPPER  = 2'd1,
        KIND_MIDDLE = 2'd2
    } piece_kind_t;

endpackage

`default_nettype wire

// ===== rtl/qtf_cut_div.sv =====
// one edge intersection: |dx|*dy / den, long division one quotient bit per stage
// then rounding fixup against the base x; takes its width default from qtf_pkg
`default_nettype none

module qtf_cut_div #(
    parameter int COORD_WIDTH = qtf_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] base,
    input  logic        [COORD_WIDTH:0]   mag,
    input  logic                          neg,
    input  logic        [COORD_WIDTH-1:0] dy,
    input  logic        [COORD_WIDTH-1:0] den,
    output logic signed [COORD_WIDTH-1:0] cut_x
);

    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;
    localparam int QW  = W + 1;
    localparam int PW  = AW + W;
    localparam int BLW = W / 2;
    localparam int BHW = W - BLW;

    // multiply, split over the dy halves
    logic [AW+BLW-1:0] pl_reg;
    logic [AW+BHW-1:0] ph_reg;
    logic [W-1:0]      m_base_reg;
    logic              m_neg_reg;
    logic [W-1:0]      m_den_reg;
    logic              m_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg     <= mag * dy[BLW-1:0];
            ph_reg     <= mag * dy[W-1:BLW];
            m_base_reg <= base;
            m_neg_reg  <= neg;
            m_den_reg  <= den;
            m_zero_reg <= (den == '0);
        end
    end

    logic [PW-1:0] prod;
    assign prod = {{BHW{1'b0}}, pl_reg} + {ph_reg, {BLW{1'b0}}};

    // divider stages, index 0 holds the summed product
    logic [W-1:0]  rem_q  [0:QW];
    logic [QW-1:0] low_q  [0:QW];
    logic [QW-1:0] quo_q  [0:QW];
    logic [W-1:0]  base_q [0:QW];
    logic [W-1:0]  den_q  [0:QW];
    logic          neg_q  [0:QW];
    logic          zero_q [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_q[0]  <= prod[PW-1:QW];
            low_q[0]  <= prod[QW-1:0];
            quo_q[0]  <= '0;
            base_q[0] <= m_base_reg;
            den_q[0]  <= m_den_reg;
            neg_q[0]  <= m_neg_reg;
            zero_q[0] <= m_zero_reg;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [W:0] trial;
        logic       ge;

        assign trial = {rem_q[i], low_q[i][QW-1]};
        assign ge    = (trial >= {1'b0, den_q[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q[i+1]  <= ge ? W'(trial - {1'b0, den_q[i]}) : trial[W-1:0];
                low_q[i+1]  <= {low_q[i][QW-2:0], 1'b0};
                quo_q[i+1]  <= {quo_q[i][QW-2:0], ge};
                base_q[i+1] <= base_q[i];
                den_q[i+1]  <= den_q[i];
                neg_q[i+1]  <= neg_q[i];
                zero_q[i+1] <= zero_q[i];
            end
        end
    end

    // fixup: base -/+ q, nudged one toward zero when the division was inexact
    logic signed [W+1:0] bx;
    logic signed [W+1:0] qx;
    logic signed [W+1:0] sum;
    logic signed [W+1:0] sum_adj;
    logic                rnz;
    logic                nudge;
    logic [W-1:0]        cut_next;
    logic [W-1:0]        cut_reg;

    always_comb
    begin
        bx      = {{2{base_q[QW][W-1]}}, base_q[QW]};
        qx      = {1'b0, quo_q[QW]};
        rnz     = (rem_q[QW] != '0);
        sum     = neg_q[QW] ? (bx + qx) : (bx - qx);
        sum_adj = neg_q[QW] ? (sum + 2'sd1) : (sum - 2'sd1);
        if (neg_q[QW])
            nudge = rnz && sum[W+1];
        else
            nudge = rnz && !sum[W+1] && (sum != '0);
        if (zero_q[QW])
            cut_next = base_q[QW];
        else if (nudge)
            cut_next = sum_adj[W-1:0];
        else
            cut_next = sum[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cut_reg <= cut_next;
    end

    assign cut_x = $signed(cut_reg);

endmodule

`default_nettype wire

// ===== rtl/quad_trapezoid_fracture.sv =====
// Quadrilateral to flat-topped trapezoid fracture.
// Input channel (in_valid / in_stall): four signed corners and a speed tag; an
// item is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): up to three pieces per item in the
// order lower, upper, middle; last_piece marks the final piece of an item.
// Pieces not taller than height_tolerance are dropped; an item may give none.
// cfg_write_en / cfg_write_data write height_tolerance (reset value 5).
// Pipeline: input register, three sort passes, cut setup, two multiply stages,
// COORD_WIDTH + 1 divider stages, fixup, output.
// Throughput: one item per cycle enters the pipeline while in_stall is low;
// the single output port drains one piece per cycle while out_stall is low,
// so the next item is loaded only as the last piece of the current one is
// taken; an item with no piece does not hold the output stage.
// When out_stall is held, gaps in the pipeline close up until a finished item
// waits at its end; then the pipeline freezes and in_stall rises; nothing is
// lost or repeated.
// Reset clears all valid bits and the pending piece mask; the tolerance
// register returns to 5.
// Depends on qtf_pkg and qtf_cut_div.
`default_nettype none

module quad_trapezoid_fracture #(
    parameter int COORD_WIDTH = qtf_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [qtf_pkg::TOL_WIDTH-1:0]       cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_WIDTH-1:0]       corner0_x,
    input  logic signed [COORD_WIDTH-1:0]       corner0_y,
    input  logic signed [COORD_WIDTH-1:0]       corner1_x,
    input  logic signed [COORD_WIDTH-1:0]       corner1_y,
    input  logic signed [COORD_WIDTH-1:0]       corner2_x,
    input  logic signed [COORD_WIDTH-1:0]       corner2_y,
    input  logic signed [COORD_WIDTH-1:0]       corner3_x,
    input  logic signed [COORD_WIDTH-1:0]       corner3_y,
    input  logic [qtf_pkg::TAG_WIDTH-1:0]       dose_speed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [qtf_pkg::TAG_WIDTH-1:0]       speed_tag,
    output logic signed [COORD_WIDTH-1:0]       bottom_y,
    output logic signed [COORD_WIDTH-1:0]       top_y,
    output logic signed [COORD_WIDTH-1:0]       bottom_left_x,
    output logic signed [COORD_WIDTH-1:0]       bottom_right_x,
    output logic signed [COORD_WIDTH-1:0]       top_left_x,
    output logic signed [COORD_WIDTH-1:0]       top_right_x,
    output logic [1:0]                          piece_kind,
    output logic                                last_piece
);

    localparam int W  = COORD_WIDTH;
    localparam int NP = qtf_pkg::NUM_PIECES;
    localparam int QW = W + 1;
    localparam int DL = QW + 3;
    localparam int NV = 5 + DL;

    typedef struct packed {
        logic [qtf_pkg::TAG_WIDTH-1:0] speed;
        logic [3:0][W-1:0]             x;
        logic [3:0][W-1:0]             y;
    } quad_t;

    typedef struct packed {
        quad_t         quad;
        logic [NP-1:0] mask;
    } tail_t;

    logic [qtf_pkg::TOL_WIDTH-1:0] height_tolerance_reg;
    logic [NV:1]                   vld_reg;
    logic                          adv;
    logic                          load_ok;
    logic [NP-1:0]                 rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            height_tolerance_reg <= qtf_pkg::HEIGHT_TOL_RESET;
        else if (cfg_write_en)
            height_tolerance_reg <= cfg_write_data;
    end

    assign adv      = !vld_reg[NV] || load_ok;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NV-1:1], in_valid};
    end

    // input register and sort passes
    quad_t quad_reg [1:4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quad_reg[1].speed <= dose_speed;
            quad_reg[1].x[0]  <= corner0_x;
            quad_reg[1].y[0]  <= corner0_y;
            quad_reg[1].x[1]  <= corner1_x;
            quad_reg[1].y[1]  <= corner1_y;
            quad_reg[1].x[2]  <= corner2_x;
            quad_reg[1].y[2]  <= corner2_y;
            quad_reg[1].x[3]  <= corner3_x;
            quad_reg[1].y[3]  <= corner3_y;
        end
    end

    // one stable bubble pass per stage
    for (genvar s = 2; s <= 4; s++)
    begin : g_sort
        quad_t        work;
        logic [W-1:0] tx;
        logic [W-1:0] ty;

        always_comb
        begin
            work = quad_reg[s-1];
            tx   = '0;
            ty   = '0;
            for (int k = 0; k < 3; k++)
            begin
                if ($signed(work.y[k]) > $signed(work.y[k+1]))
                begin
                    tx          = work.x[k];
                    ty          = work.y[k];
                    work.x[k]   = work.x[k+1];
                    work.y[k]   = work.y[k+1];
                    work.x[k+1] = tx;
                    work.y[k+1] = ty;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                quad_reg[s] <= work;
        end
    end

    // cut setup on the sorted corners
    logic signed [W-1:0] sx0, sx1, sx2, sx3;
    logic [W-1:0]        d10, d21, d32, d31, d20, d30;
    logic                swap_edge;
    logic [W-1:0]        tol_ext;
    logic [NP-1:0]       mask_next;
    logic signed [W-1:0] up_base, dn_base, up_other;
    logic                up_neg, dn_neg;
    logic [W:0]          up_mag, dn_mag;

    always_comb
    begin
        sx0 = $signed(quad_reg[4].x[0]);
        sx1 = $signed(quad_reg[4].x[1]);
        sx2 = $signed(quad_reg[4].x[2]);
        sx3 = $signed(quad_reg[4].x[3]);
        // sorted, so every difference is nonnegative and fits in W bits
        d10 = quad_reg[4].y[1] - quad_reg[4].y[0];
        d21 = quad_reg[4].y[2] - quad_reg[4].y[1];
        d32 = quad_reg[4].y[3] - quad_reg[4].y[2];
        d31 = quad_reg[4].y[3] - quad_reg[4].y[1];
        d20 = quad_reg[4].y[2] - quad_reg[4].y[0];
        d30 = quad_reg[4].y[3] - quad_reg[4].y[0];
        swap_edge = (sx0 > sx1) != (sx3 > sx2);
        tol_ext   = W'(height_tolerance_reg);
        mask_next = '0;
        mask_next[qtf_pkg::KIND_LOWER]  = (d10 > tol_ext);
        mask_next[qtf_pkg::KIND_UPPER]  = (d32 > tol_ext);
        mask_next[qtf_pkg::KIND_MIDDLE] = (d21 > tol_ext);
        up_base  = sx3;
        up_other = swap_edge ? sx1 : sx0;
        dn_base  = swap_edge ? sx2 : sx3;
        up_neg   = (up_base < up_other);
        dn_neg   = (dn_base < sx0);
        up_mag   = up_neg ? ({up_other[W-1], up_other} - {up_base[W-1], up_base})
                          : ({up_base[W-1], up_base} - {up_other[W-1], up_other});
        dn_mag   = dn_neg ? ({sx0[W-1], sx0} - {dn_base[W-1], dn_base})
                          : ({dn_base[W-1], dn_base} - {sx0[W-1], sx0});
    end

    logic signed [W-1:0] up_base_reg, dn_base_reg;
    logic [W:0]          up_mag_reg, dn_mag_reg;
    logic                up_neg_reg, dn_neg_reg;
    logic [W-1:0]        up_dy_reg, up_den_reg, dn_dy_reg, dn_den_reg;
    tail_t               tail_reg [0:DL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            up_base_reg        <= up_base;
            up_mag_reg         <= up_mag;
            up_neg_reg         <= up_neg;
            up_dy_reg          <= d32;
            up_den_reg         <= swap_edge ? d31 : d30;
            dn_base_reg        <= dn_base;
            dn_mag_reg         <= dn_mag;
            dn_neg_reg         <= dn_neg;
            dn_dy_reg          <= swap_edge ? d21 : d31;
            dn_den_reg         <= swap_edge ? d20 : d30;
            tail_reg[0].quad   <= quad_reg[4];
            tail_reg[0].mask   <= mask_next;
        end
    end

    for (genvar t = 1; t <= DL; t++)
    begin : g_tail
        always_ff @(posedge clk)
        begin
            if (adv)
                tail_reg[t] <= tail_reg[t-1];
        end
    end

    logic signed [W-1:0] xu, xd;

    qtf_cut_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cut_up (
        .clk  (clk),
        .en   (adv),
        .base (up_base_reg),
        .mag  (up_mag_reg),
        .neg  (up_neg_reg),
        .dy   (up_dy_reg),
        .den  (up_den_reg),
        .cut_x(xu)
    );

    qtf_cut_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cut_dn (
        .clk  (clk),
        .en   (adv),
        .base (dn_base_reg),
        .mag  (dn_mag_reg),
        .neg  (dn_neg_reg),
        .dy   (dn_dy_reg),
        .den  (dn_den_reg),
        .cut_x(xd)
    );

    // output stage: holds one item's pieces and drains them in order
    quad_t               em_quad_reg;
    logic signed [W-1:0] xdl_reg, xdr_reg, xul_reg, xur_reg;
    logic [NP-1:0]       low_bit;
    logic                single;
    logic                load;
    logic signed [W-1:0] tx1, tx2;

    assign low_bit = rem_reg & (~rem_reg + 1'b1);
    assign single  = (rem_reg != '0) && ((rem_reg & (rem_reg - 1'b1)) == '0);
    assign load_ok = (rem_reg == '0) || (single && !out_stall);
    assign load    = adv && vld_reg[NV];
    assign tx1     = $signed(tail_reg[DL].quad.x[1]);
    assign tx2     = $signed(tail_reg[DL].quad.x[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else if (load)
            rem_reg <= tail_reg[DL].mask;
        else if (out_valid && !out_stall)
            rem_reg <= rem_reg & ~low_bit;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            em_quad_reg <= tail_reg[DL].quad;
            xdl_reg     <= (xd < tx1) ? xd : tx1;
            xdr_reg     <= (xd < tx1) ? tx1 : xd;
            xul_reg     <= (xu < tx2) ? xu : tx2;
            xur_reg     <= (xu < tx2) ? tx2 : xu;
        end
    end

    qtf_pkg::piece_kind_t kind;

    always_comb
    begin
        priority if (rem_reg[qtf_pkg::KIND_LOWER])
            kind = qtf_pkg::KIND_LOWER;
        else if (rem_reg[qtf_pkg::KIND_UPPER])
            kind = qtf_pkg::KIND_UPPER;
        else
            kind = qtf_pkg::KIND_MIDDLE;
    end

    always_comb
    begin
        unique case (kind)
            qtf_pkg::KIND_LOWER:
            begin
                bottom_y       = $signed(em_quad_reg.y[0]);
                top_y          = $signed(em_quad_reg.y[1]);
                bottom_left_x  = $signed(em_quad_reg.x[0]);
                bottom_right_x = $signed(em_quad_reg.x[0]);
                top_left_x     = xdl_reg;
                top_right_x    = xdr_reg;
            end
            qtf_pkg::KIND_UPPER:
            begin
                bottom_y       = $signed(em_quad_reg.y[2]);
                top_y          = $signed(em_quad_reg.y[3]);
                bottom_left_x  = xul_reg;
                bottom_right_x = xur_reg;
                top_left_x     = $signed(em_quad_reg.x[3]);
                top_right_x    = $signed(em_quad_reg.x[3]);
            end
            default:
            begin
                bottom_y       = $signed(em_quad_reg.y[1]);
                top_y          = $signed(em_quad_reg.y[2]);
                bottom_left_x  = xdl_reg;
                bottom_right_x = xdr_reg;
                top_left_x     = xul_reg;
                top_right_x    = xur_reg;
            end
        endcase
    end

    assign out_valid  = (rem_reg != '0);
    assign speed_tag  = em_quad_reg.speed;
    assign piece_kind = kind;
    assign last_piece = single;

endmodule

`default_nettype wire

// ===== rtl/qtf_checker.sv =====
// port-level checks for the quadrilateral fracture block, bound to the top level
// depends on qtf_pkg and quad_trapezoid_fracture_assert.svh
`default_nettype none

`include "quad_trapezoid_fracture_assert.svh"

module qtf_checker #(
    parameter int COORD_WIDTH = qtf_pkg::COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH-1:0] bottom_y,
    input logic signed [COORD_WIDTH-1:0] top_y,
    input logic signed [COORD_WIDTH-1:0] bottom_left_x,
    input logic signed [COORD_WIDTH-1:0] bottom_right_x,
    input logic signed [COORD_WIDTH-1:0] top_left_x,
    input logic signed [COORD_WIDTH-1:0] top_right_x,
    input logic [1:0]                    piece_kind,
    input logic                          last_piece
);

    `QTF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bottom_y) && $stable(piece_kind), "output item changed while stalled")
    `QTF_ASSERT_IMP(a_height_pos, out_valid, top_y > bottom_y, "piece with no height")
    `QTF_ASSERT_IMP(a_lower_tip, out_valid && piece_kind == qtf_pkg::KIND_LOWER, bottom_left_x == bottom_right_x && top_left_x <= top_right_x, "lower piece malformed")
    `QTF_ASSERT_IMP(a_upper_tip, out_valid && piece_kind == qtf_pkg::KIND_UPPER, top_left_x == top_right_x && bottom_left_x <= bottom_right_x, "upper piece malformed")
    `QTF_ASSERT_NXT(a_more_pieces, out_valid && !out_stall && !last_piece, out_valid, "item ended before last piece")

endmodule

bind quad_trapezoid_fracture qtf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_qtf_checker (.*);

`default_nettype wire
